### rtl/kvlt_pkg.sv
// ----------------------------------------------------------------------------
// kvlt_pkg
// Shared constants, codes and control types for the key/value linear table.
// ----------------------------------------------------------------------------
package kvlt_pkg;

    // default configuration
    localparam int ENTRIES_DEF    = 16;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // packed stream widths
    localparam int IN_DATA_W  = KEY_W + DATA_W;
    localparam int OUT_FIELDS = 1 + DATA_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;

    // request opcodes
    typedef enum logic
    {
        OP_SET = 1'b0,
        OP_GET = 1'b1
    } opcode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0]
    {
        STAT_INSERTED = 2'd0,
        STAT_PRESENT  = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_GET      = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed
    {
        logic load;     // capture the request word
        logic scan;     // step the key search
        logic vread;    // fetch the value of the matched entry
        logic finish;   // update table, load the result register
    } kvlt_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic scan_done;  // search ended, no read outstanding
        logic out_free;   // result register can take a new word
    } kvlt_stat_t;

endpackage

### rtl/key_value_linear_table_core.sv
// ----------------------------------------------------------------------------
// key_value_linear_table_core
// Insertion-ordered key/value table with linear search, set and get requests.
// ----------------------------------------------------------------------------
// The stored keys sit in a one-port memory and are read and compared one per
// cycle, so the search loop over the used entries sets how long a request
// takes; a hit ends the search early. One request is worked on at a time; the
// next is accepted the cycle after the previous result has been loaded into
// the output register, even while that word still waits for m_tready. A set
// of a new key appends it, a set of a present key changes nothing, a set into
// a full table is dropped with a full status. Every result carries the entry
// count after the request. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module key_value_linear_table_core
    import kvlt_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key[31:0], value_in[63:32]
    input  logic                  s_tuser,   // opcode[0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // found[0], value_out[32:1],
                                             // entry_count[37:33], zero pad
    output logic [STATUS_W-1:0]   m_tuser    // status[1:0]
);

    kvlt_cmd_t           cmd;
    kvlt_stat_t          stat;
    logic                found;
    logic [DATA_W-1:0]   value_out;
    logic [COUNT_W-1:0]  entry_count;

    // sequencer
    kvlt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and search datapath
    kvlt_datapath #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_opcode  (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_value   (s_tdata[KEY_W +: DATA_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_found  (found),
        .out_value  (value_out),
        .out_count  (entry_count)
    );

    // result word packing
    assign m_tdata = OUT_DATA_W'({entry_count, value_out, found});

endmodule

### rtl/kvlt_ctrl.sv
// ----------------------------------------------------------------------------
// kvlt_ctrl
// Request sequencer: accept, search, value fetch, result hand-off.
// ----------------------------------------------------------------------------
module kvlt_ctrl
    import kvlt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  kvlt_stat_t stat,
    output kvlt_cmd_t  cmd
);

    typedef enum logic [3:0]
    {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_VREAD = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_VREAD;
                end
            end
            ST_VREAD:
            begin
                cmd.vread  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/kvlt_datapath.sv
// ----------------------------------------------------------------------------
// kvlt_datapath
// Key and value memories, search counter, comparator and result register.
// ----------------------------------------------------------------------------
module kvlt_datapath
    import kvlt_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  kvlt_cmd_t           cmd,
    output kvlt_stat_t          stat,
    input  logic                in_opcode,
    input  logic [KEY_W-1:0]    in_key,
    input  logic [DATA_W-1:0]   in_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_found,
    output logic [DATA_W-1:0]   out_value,
    output logic [COUNT_W-1:0]  out_count
);

    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int STORE_W = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;

    // table storage, undefined until written
    logic [KEY_W-1:0]   key_mem [ENTRIES];
    logic [STORE_W-1:0] val_mem [ENTRIES];

    // request word
    logic                op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [STORE_W-1:0]  val_reg;

    // search state
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic                cmp_valid_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [KEY_W-1:0]    key_q_reg;
    logic [STORE_W-1:0]  val_q_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                found_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic                issue;
    logic                match;
    logic                full;
    logic                do_insert;
    logic [CNT_W-1:0]    used_next;
    status_t             status_next;

    // search control
    assign issue = cmd.scan && !hit_reg && (rd_idx_reg != used_reg);
    assign match = cmp_valid_reg && !hit_reg && (key_q_reg == key_reg);
    assign full  = (used_reg == CNT_W'(ENTRIES));

    assign stat.scan_done = !cmp_valid_reg && (hit_reg || (rd_idx_reg == used_reg));
    assign stat.out_free  = !out_valid_reg || out_ready;

    // insert decision and result status
    assign do_insert = cmd.finish && (op_reg == OP_SET) && !hit_reg && !full;
    assign used_next = do_insert ? (used_reg + CNT_W'(1)) : used_reg;

    always_comb
    begin
        if (op_reg == OP_GET)
        begin
            status_next = STAT_GET;
        end
        else if (hit_reg)
        begin
            status_next = STAT_PRESENT;
        end
        else if (full)
        begin
            status_next = STAT_FULL;
        end
        else
        begin
            status_next = STAT_INSERTED;
        end
    end

    // memories: insert write, registered reads
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            key_mem[used_reg[IDX_W-1:0]] <= key_reg;
            val_mem[used_reg[IDX_W-1:0]] <= val_reg;
        end
        if (issue)
        begin
            key_q_reg <= key_mem[rd_idx_reg[IDX_W-1:0]];
        end
        if (cmd.vread)
        begin
            val_q_reg <= val_mem[hit_idx_reg];
        end
    end

    // request capture and compare tracking
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_opcode;
            key_reg <= in_key;
            val_reg <= in_value[STORE_W-1:0];
        end
        if (issue)
        begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (cmd.load)
        begin
            hit_idx_reg <= '0;
        end
        else if (match)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
    end

    // search control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            cmp_valid_reg <= issue;
            if (cmd.load)
            begin
                rd_idx_reg <= '0;
                hit_reg    <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= status_next;
            found_reg  <= hit_reg;
            value_reg  <= ((op_reg == OP_GET) && hit_reg) ? DATA_W'(val_q_reg) : '0;
            count_reg  <= COUNT_W'(used_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_found  = found_reg;
    assign out_value  = value_reg;
    assign out_count  = count_reg;

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key/value linear table core. A shadow copy of
// the table predicts each result word; random source and sink stalls shake
// the handshakes while the table grows from empty to full and is then hit
// with mixed set/get traffic.
// ----------------------------------------------------------------------------
module tb_top;
    import kvlt_pkg::*;

    localparam int DEPTH       = ENTRIES_DEF;
    localparam int TOTAL_ITEMS = 1700;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed
    {
        status_t             status;
        logic                found;
        logic [DATA_W-1:0]   value;
        logic [COUNT_W-1:0]  count;
    } kv_result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // shadow copy of the table
    logic [KEY_W-1:0]  shadow_key   [DEPTH];
    logic [DATA_W-1:0] shadow_value [DEPTH];
    int                shadow_used = 0;

    kv_result_t pending_results [$];
    int         error_count  = 0;
    int         item_count   = 0;
    int         watchdog_cnt = 0;
    int         n_inserted = 0, n_present = 0, n_full = 0, n_hit = 0, n_miss = 0;
    bit         src_idle  = 1'b0;
    bit         sink_idle = 1'b0;

    key_value_linear_table_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // key[31:0], value_in[63:32]
        .s_tuser  (s_tuser),   // opcode[0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // found[0], value_out[32:1], entry_count[37:33]
        .m_tuser  (m_tuser)    // status[1:0]
    );

    // clock
    always #6 clk = ~clk;

    // apply one request to the shadow table and return the word it should give
    function automatic kv_result_t table_apply(opcode_t op, logic [KEY_W-1:0] key,
                                               logic [DATA_W-1:0] value);
        kv_result_t res;
        int         hit_idx;
        hit_idx = -1;
        for (int i = 0; i < shadow_used; i++)
        begin
            if (hit_idx < 0 && shadow_key[i] == key)
                hit_idx = i;
        end
        res.found = (hit_idx >= 0);
        res.value = '0;
        if (op == OP_SET)
        begin
            if (res.found)
            begin
                res.status = STAT_PRESENT;
                n_present++;
            end
            else if (shadow_used >= DEPTH)
            begin
                res.status = STAT_FULL;
                n_full++;
            end
            else
            begin
                shadow_key[shadow_used]   = key;
                shadow_value[shadow_used] = value;
                shadow_used++;
                res.status = STAT_INSERTED;
                n_inserted++;
            end
        end
        else
        begin
            res.status = STAT_GET;
            if (res.found)
            begin
                res.value = shadow_value[hit_idx];
                n_hit++;
            end
            else
                n_miss++;
        end
        res.count = COUNT_W'(shadow_used);
        return res;
    endfunction

    // stored keys half the time, some near misses, extremes and fresh random keys
    function automatic logic [KEY_W-1:0] pick_key();
        int               sel;
        logic [KEY_W-1:0] key;
        sel = $urandom_range(0, 9);
        key = $urandom();
        if (shadow_used > 0 && sel < 5)
            key = shadow_key[$urandom_range(0, shadow_used - 1)];
        else if (shadow_used > 0 && sel == 5)
            key = shadow_key[$urandom_range(0, shadow_used - 1)]
                  ^ (32'd1 << $urandom_range(0, KEY_W - 1));
        else if (sel == 6)
            key = $urandom_range(0, 1) ? '1 : '0;
        return key;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return $urandom();
    endfunction

    // compare one field, report on mismatch
    function automatic void check_field(string name, logic [31:0] exp_val,
                                        logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name,
                     exp_val, act_val);
            error_count++;
        end
    endfunction

    // send one request word, first stalling the source for a random gap when src_idle is set
    task automatic send_request(opcode_t op, logic [KEY_W-1:0] key,
                                logic [DATA_W-1:0] value);
        int gap;
        gap = src_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {value, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(table_apply(op, key, value));
        item_count++;
    endtask

    // set_weight: chance of a set out of eight
    task automatic send_random(int set_weight);
        opcode_t op;
        op = ($urandom_range(0, 7) < set_weight) ? OP_SET : OP_GET;
        send_request(op, pick_key(), pick_value());
    endtask

    task automatic shuffle_idle();
        src_idle  = $urandom_range(0, 1);
        sink_idle = $urandom_range(0, 1);
    endtask

    // hold the source until every outstanding word is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // empty table, key and value extremes, insert / present / hit / miss
    task automatic test_empty_table();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_SET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
        send_request(OP_SET, 32'h8000_0000, 32'h5A5A_A5A5);
        send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    endtask

    // grow the table slowly so every entry count sees many lookups
    task automatic test_fill_table();
        while (shadow_used < DEPTH)
        begin
            if (item_count % 48 == 0)
                shuffle_idle();
            send_random(1);
        end
    endtask

    // drained pause, then the full-table cases
    task automatic test_full_table();
        logic [KEY_W-1:0] fresh_key;
        wait_for_results();
        fresh_key = $urandom();
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        send_request(OP_SET, fresh_key, 32'hDEAD_BEEF);
        send_request(OP_SET, shadow_key[DEPTH-1], 32'h0000_0000);
        send_request(OP_GET, shadow_key[DEPTH-1], 32'h0000_0000);
        send_request(OP_GET, shadow_key[0], 32'hFFFF_FFFF);
        send_request(OP_GET, fresh_key, 32'h0000_0000);
    endtask

    // mixed traffic against the full table
    task automatic test_random_traffic();
        while (item_count < TOTAL_ITEMS)
        begin
            if (item_count % 64 == 0)
                shuffle_idle();
            send_random(4);
        end
    endtask

    // reset, then the tests in turn
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_fill_table();
        test_full_table();
        test_random_traffic();
        wait_for_results();
        repeat (DEPTH + 8) @(posedge clk);
        $display("run covered %0d requests, entry counts 0 to %0d", item_count, shadow_used);
        $display("sets: %0d inserted, %0d present, %0d full; gets: %0d hits, %0d misses",
                 n_inserted, n_present, n_full, n_hit, n_miss);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result sink with random back-pressure
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = sink_idle ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // result word checker
    always @(posedge clk)
    begin
        kv_result_t exp_res;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got tdata %0h tuser %0h",
                         $time, m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                check_field("status", exp_res.status, m_tuser);
                check_field("found", exp_res.found, m_tdata[0]);
                check_field("value_out", exp_res.value, m_tdata[32:1]);
                check_field("entry_count", exp_res.count, m_tdata[37:33]);
            end
        end
    end

    // watchdog on cycles with no word moved
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            watchdog_cnt <= 0;
        else
            watchdog_cnt <= watchdog_cnt + 1;
        if (watchdog_cnt >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, watchdog_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
